### hdl/eihp_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
`timescale 1ns / 1ps

package eihp_pkg;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_VLAN = 6'b000010,
        PH_IP   = 6'b000100,
        PH_TCP  = 6'b001000,
        PH_UDP  = 6'b010000,
        PH_PAY  = 6'b100000
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_ETYPE = 2'd0;
    localparam logic [1:0] ERR_PROTO = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [3:0] LEN_MASK     = 4'h0f;
    localparam logic [5:0] MAC_LEN      = 6'd6;
    localparam logic [5:0] ETYPE_OFF    = 6'd12;
    localparam logic [5:0] VLAN_LAST    = 6'd3;   // last byte of the 4-byte tag
    localparam logic [5:0] IP_PROTO_OFF = 6'd9;
    localparam logic [5:0] IP_SRC_OFF   = 6'd12;
    localparam logic [5:0] IP_DST_OFF   = 6'd16;
    localparam logic [5:0] IP_DST_END   = 6'd20;
    localparam logic [5:0] PORT_SRC_END = 6'd2;
    localparam logic [5:0] PORT_DST_END = 6'd4;
    localparam logic [5:0] TCP_DOFF_OFF = 6'd12;
    localparam logic [5:0] TCP_FLAG_OFF = 6'd13;
    localparam logic [6:0] MIN_HDR_LEN  = 7'd20;
    localparam logic [6:0] UDP_HDR_LEN  = 7'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic        is_udp;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [1:0]  error_code;
        logic [7:0]  payload_byte;
        logic        frame_end;
    } t_result;

endpackage

### hdl/eihp_core.sv
// Header parse state and per-byte next-state and result logic.
`timescale 1ns / 1ps

module eihp_core
    import eihp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_off, n_off;
    logic [5:0]  r_ihl, n_ihl;
    logic [5:0]  r_tcp_len, n_tcp_len;
    logic [47:0] r_mac0, n_mac0;
    logic [47:0] r_mac1, n_mac1;
    logic [15:0] r_etype, n_etype;
    logic [31:0] r_ip0, n_ip0;
    logic [31:0] r_ip1, n_ip1;
    logic        r_udp, n_udp;
    logic [15:0] r_port0, n_port0;
    logic [15:0] r_port1, n_port1;
    logic [7:0]  r_flags, n_flags;
    logic        r_drop, n_drop;

    always_comb begin
        logic       do_err;
        logic       do_hdr;
        logic       do_pay;
        logic [1:0] code;
        logic [6:0] off_inc;
        logic [6:0] hdr_end;
        logic [15:0] et;

        do_err  = 1'b0;
        do_hdr  = 1'b0;
        do_pay  = 1'b0;
        code    = ERR_ETYPE;
        off_inc = {1'b0, r_off} + 7'd1;
        hdr_end = MIN_HDR_LEN;
        et      = {r_etype[15:8], i_data};

        n_phase   = r_phase;
        n_off     = r_off;
        n_ihl     = r_ihl;
        n_tcp_len = r_tcp_len;
        n_mac0    = r_mac0;
        n_mac1    = r_mac1;
        n_etype   = r_etype;
        n_ip0     = r_ip0;
        n_ip1     = r_ip1;
        n_udp     = r_udp;
        n_port0   = r_port0;
        n_port1   = r_port1;
        n_flags   = r_flags;
        n_drop    = r_drop;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            if (r_drop) begin
                if (i_last) begin
                    n_phase = PH_ETH;
                    n_off   = '0;
                    n_drop  = 1'b0;
                end
            end else begin
                n_off = off_inc[5:0];
                case (r_phase)
                    PH_ETH: begin
                        if (r_off < MAC_LEN) begin
                            n_mac0 = {r_mac0[39:0], i_data};
                        end else if (r_off < ETYPE_OFF) begin
                            n_mac1 = {r_mac1[39:0], i_data};
                        end else if (r_off == ETYPE_OFF) begin
                            n_etype = {i_data, 8'h00};
                        end else begin
                            n_etype = et;
                            if (et == ETYPE_IPV4) begin
                                n_phase = PH_IP;
                                n_off   = '0;
                            end else if (et == ETYPE_VLAN) begin
                                n_phase = PH_VLAN;
                                n_off   = '0;
                            end else begin
                                do_err = 1'b1;
                                code   = ERR_ETYPE;
                            end
                        end
                    end
                    PH_VLAN: begin
                        if (r_off >= VLAN_LAST) begin
                            n_phase = PH_IP;
                            n_off   = '0;
                        end
                    end
                    PH_IP: begin
                        if (r_off == '0) begin
                            n_ihl = {i_data[3:0] & LEN_MASK, 2'b00};
                        end else if (r_off == IP_PROTO_OFF) begin
                            if (i_data == PROTO_TCP) begin
                                n_udp = 1'b0;
                            end else if (i_data == PROTO_UDP) begin
                                n_udp = 1'b1;
                            end else begin
                                do_err = 1'b1;
                                code   = ERR_PROTO;
                            end
                        end else if (r_off >= IP_SRC_OFF && r_off < IP_DST_OFF) begin
                            n_ip0 = {r_ip0[23:0], i_data};
                        end else if (r_off >= IP_DST_OFF && r_off < IP_DST_END) begin
                            n_ip1 = {r_ip1[23:0], i_data};
                        end
                        if ({1'b0, n_ihl} > MIN_HDR_LEN) begin
                            hdr_end = {1'b0, n_ihl};
                        end
                        if (!do_err && off_inc >= hdr_end) begin
                            n_phase   = n_udp ? PH_UDP : PH_TCP;
                            n_off     = '0;
                            n_tcp_len = '0;
                            n_flags   = '0;
                        end
                    end
                    PH_TCP: begin
                        if (r_off < PORT_SRC_END) begin
                            n_port0 = {r_port0[7:0], i_data};
                        end else if (r_off < PORT_DST_END) begin
                            n_port1 = {r_port1[7:0], i_data};
                        end else if (r_off == TCP_DOFF_OFF) begin
                            n_tcp_len = {i_data[7:4] & LEN_MASK, 2'b00};
                        end else if (r_off == TCP_FLAG_OFF) begin
                            n_flags = i_data;
                        end
                        if ({1'b0, n_tcp_len} > MIN_HDR_LEN) begin
                            hdr_end = {1'b0, n_tcp_len};
                        end
                        do_hdr = (off_inc >= hdr_end);
                    end
                    PH_UDP: begin
                        if (r_off < PORT_SRC_END) begin
                            n_port0 = {r_port0[7:0], i_data};
                        end else if (r_off < PORT_DST_END) begin
                            n_port1 = {r_port1[7:0], i_data};
                        end
                        do_hdr = (off_inc >= UDP_HDR_LEN);
                    end
                    PH_PAY: begin
                        do_pay = 1'b1;
                    end
                    default: begin
                        n_phase = PH_ETH;
                        n_off   = '0;
                    end
                endcase

                // A frame that ends with the headers still open is truncated.
                if (!do_err && !do_hdr && !do_pay && i_last) begin
                    do_err = 1'b1;
                    code   = ERR_TRUNC;
                end

                o_res.frame_end = i_last;
                if (do_err) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERR;
                    o_res.error_code = code;
                    if (!i_last) begin
                        n_drop = 1'b1;
                    end
                end else if (do_hdr) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_HDR;
                    o_res.dst_mac   = n_mac0;
                    o_res.src_mac   = n_mac1;
                    o_res.src_ip    = n_ip0;
                    o_res.dst_ip    = n_ip1;
                    o_res.is_udp    = n_udp;
                    o_res.src_port  = n_port0;
                    o_res.dst_port  = n_port1;
                    o_res.tcp_flags = n_flags;
                    n_phase = PH_PAY;
                    n_off   = '0;
                end else if (do_pay) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAY;
                    o_res.payload_byte = i_data;
                    n_off = '0;
                end
                if (o_res_valid && i_last) begin
                    n_phase = PH_ETH;
                    n_off   = '0;
                    n_drop  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ETH;
            r_off     <= '0;
            r_ihl     <= '0;
            r_tcp_len <= '0;
            r_mac0    <= '0;
            r_mac1    <= '0;
            r_etype   <= '0;
            r_ip0     <= '0;
            r_ip1     <= '0;
            r_udp     <= 1'b0;
            r_port0   <= '0;
            r_port1   <= '0;
            r_flags   <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_ihl     <= n_ihl;
            r_tcp_len <= n_tcp_len;
            r_mac0    <= n_mac0;
            r_mac1    <= n_mac1;
            r_etype   <= n_etype;
            r_ip0     <= n_ip0;
            r_ip1     <= n_ip1;
            r_udp     <= n_udp;
            r_port0   <= n_port0;
            r_port1   <= n_port1;
            r_flags   <= n_flags;
            r_drop    <= n_drop;
        end
    end

endmodule

### hdl/eth_ipv4_l4_header_parser_unit.sv
// Top level of the Ethernet/IPv4/TCP-UDP header parser with its stream registers.
`timescale 1ns / 1ps
//
// Usage:
//   The slave stream carries one frame byte per item in tdata, with tlast on the
//   final byte of each frame. The master stream carries at most one result per
//   input byte: tuser holds the kind (header record, payload byte or error),
//   tdata the packed result fields, tlast marks the result caused by the frame's
//   last byte. Bytes that produce no result (header bytes, dropped bytes after
//   an error) are absorbed silently.
// Pipeline and throughput:
//   One item per cycle sustained while no result waits downstream. An item
//   sits in the input register while the parser logic computes its result;
//   the output register takes it when the parser steps. The rate is set by
//   the combinational parser update between the two registers.
// Reset:
//   Synchronous, active low. Both registers empty, parser waits for the start
//   of a frame.
// Stall:
//   While a result waits, one more input item is still taken into the input
//   register; after that o_s_axis_tready stays low until the result is taken.

module eth_ipv4_l4_header_parser_unit
    import eihp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // data_byte[7:0]
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // dst_mac[47:0], src_mac[95:48], src_ip[127:96], dst_ip[159:128], is_udp[160],
    // src_port[176:161], dst_port[192:177], tcp_flags[200:193],
    // error_code[202:201], payload_byte[210:203], zero fill[215:211]
    output logic [215:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // kind[1:0]
    output logic         o_m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;

    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    eihp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data      (r_in_data),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.frame_end;
    assign o_m_axis_tdata  = {5'b00000, r_out.payload_byte, r_out.error_code,
                              r_out.tcp_flags, r_out.dst_port, r_out.src_port,
                              r_out.is_udp, r_out.dst_ip, r_out.src_ip,
                              r_out.src_mac, r_out.dst_mac};

`ifndef ASSERT_OFF
    // The input side only stalls while a result is blocked downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_s_axis_tready) |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a blocked result");

    // A result produced by the parser is presented on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res_valid) |=> o_m_axis_tvalid)
        else $error("parser result not presented");

    // Kind is never the unused code.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("illegal result kind");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for the Ethernet/IPv4/TCP-UDP header parser unit.
`timescale 1ns / 1ps

module tb
    import eihp_pkg::*;
();

    localparam int RANDOM_FILL = -1;   // frame bytes drawn at random
    localparam int RANDOM_CUT  = -1;   // frame cut at a random length
    localparam int NO_CUT      = 0;

    // One frame to be built: header choices, payload size, content and cut point.
    typedef struct packed {
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [3:0]  doff;
        int          pay_len;
        int          fill;
        int          cut;
    } t_frame_spec;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata;   // data_byte[7:0]
    logic         i_s_axis_tlast;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // dst_mac, src_mac, src_ip, dst_ip, is_udp, src_port, dst_port, tcp_flags,
    // error_code, payload_byte, zero fill
    logic [215:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;   // kind[1:0]
    logic         o_m_axis_tlast;

    eth_ipv4_l4_header_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Parser state as the testbench sees it.
    t_phase      cur_phase;
    logic [15:0] byte_pos;
    logic [5:0]  ihl_bytes;
    logic [5:0]  tcp_hdr_bytes;
    logic [47:0] mac_addr [2];
    logic [15:0] etype_word;
    logic [31:0] ip_addr [2];
    logic        l4_is_udp;
    logic [15:0] l4_port [2];
    logic [7:0]  tcp_flag_byte;
    logic        drop_rest;

    t_result parse_results_q[$];
    int      error_count = 0;
    int      bytes_sent = 0;
    bit      src_idle_en = 1'b1;
    bit      sink_stall_en = 1'b1;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task automatic clear_parser_state();
        cur_phase     = PH_ETH;
        byte_pos      = '0;
        drop_rest     = 1'b0;
        ihl_bytes     = '0;
        tcp_hdr_bytes = '0;
        mac_addr[0]   = '0;
        mac_addr[1]   = '0;
        etype_word    = '0;
        ip_addr[0]    = '0;
        ip_addr[1]    = '0;
        l4_is_udp     = 1'b0;
        l4_port[0]    = '0;
        l4_port[1]    = '0;
        tcp_flag_byte = '0;
    endtask

    task automatic restart_frame();
        cur_phase = PH_ETH;
        byte_pos  = '0;
        drop_rest = 1'b0;
    endtask

    task automatic raise_error(input logic [1:0] code, input logic is_last);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERR;
        r.error_code = code;
        r.frame_end  = is_last;
        parse_results_q.push_back(r);
        if (is_last)
            restart_frame();
        else
            drop_rest = 1'b1;
    endtask

    task automatic emit_header_record(input logic is_last);
        t_result r;
        r           = '0;
        r.kind      = KIND_HDR;
        r.dst_mac   = mac_addr[0];
        r.src_mac   = mac_addr[1];
        r.src_ip    = ip_addr[0];
        r.dst_ip    = ip_addr[1];
        r.is_udp    = l4_is_udp;
        r.src_port  = l4_port[0];
        r.dst_port  = l4_port[1];
        r.tcp_flags = tcp_flag_byte;
        r.frame_end = is_last;
        parse_results_q.push_back(r);
        cur_phase = PH_PAY;
        byte_pos  = '0;
        if (is_last)
            restart_frame();
    endtask

    // Advances the parser state by one frame byte and queues the result it causes.
    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        t_result r;
        int      pos;
        int      hdr_end;
        pos = int'(byte_pos);
        if (drop_rest) begin
            if (is_last)
                restart_frame();
            return;
        end
        byte_pos = byte_pos + 16'd1;
        case (cur_phase)
            PH_ETH: begin
                if (pos < MAC_LEN) begin
                    mac_addr[0] = {mac_addr[0][39:0], b};
                end else if (pos < ETYPE_OFF) begin
                    mac_addr[1] = {mac_addr[1][39:0], b};
                end else if (pos == ETYPE_OFF) begin
                    etype_word = {b, 8'h00};
                end else begin
                    etype_word[7:0] = b;
                    if (etype_word == ETYPE_IPV4) begin
                        cur_phase = PH_IP;
                        byte_pos  = '0;
                    end else if (etype_word == ETYPE_VLAN) begin
                        cur_phase = PH_VLAN;
                        byte_pos  = '0;
                    end else begin
                        raise_error(ERR_ETYPE, is_last);
                        return;
                    end
                end
            end
            PH_VLAN: begin
                if (pos >= VLAN_LAST) begin
                    cur_phase = PH_IP;
                    byte_pos  = '0;
                end
            end
            PH_IP: begin
                if (pos == 0) begin
                    ihl_bytes = {b[3:0] & LEN_MASK, 2'b00};
                end else if (pos == IP_PROTO_OFF) begin
                    if (b == PROTO_TCP) begin
                        l4_is_udp = 1'b0;
                    end else if (b == PROTO_UDP) begin
                        l4_is_udp = 1'b1;
                    end else begin
                        raise_error(ERR_PROTO, is_last);
                        return;
                    end
                end else if (pos >= IP_SRC_OFF && pos < IP_DST_OFF) begin
                    ip_addr[0] = {ip_addr[0][23:0], b};
                end else if (pos >= IP_DST_OFF && pos < IP_DST_END) begin
                    ip_addr[1] = {ip_addr[1][23:0], b};
                end
                // An IHL below five still means a plain 20-byte header.
                hdr_end = int'((ihl_bytes < MIN_HDR_LEN) ? MIN_HDR_LEN : {1'b0, ihl_bytes});
                if (pos + 1 >= hdr_end) begin
                    cur_phase     = l4_is_udp ? PH_UDP : PH_TCP;
                    byte_pos      = '0;
                    tcp_hdr_bytes = '0;
                    tcp_flag_byte = '0;
                end
            end
            PH_TCP: begin
                if (pos < PORT_SRC_END)
                    l4_port[0] = {l4_port[0][7:0], b};
                else if (pos < PORT_DST_END)
                    l4_port[1] = {l4_port[1][7:0], b};
                else if (pos == TCP_DOFF_OFF)
                    tcp_hdr_bytes = {b[7:4], 2'b00};
                else if (pos == TCP_FLAG_OFF)
                    tcp_flag_byte = b;
                hdr_end = int'((tcp_hdr_bytes < MIN_HDR_LEN) ? MIN_HDR_LEN
                                                             : {1'b0, tcp_hdr_bytes});
                if (pos + 1 >= hdr_end) begin
                    emit_header_record(is_last);
                    return;
                end
            end
            PH_UDP: begin
                if (pos < PORT_SRC_END)
                    l4_port[0] = {l4_port[0][7:0], b};
                else if (pos < PORT_DST_END)
                    l4_port[1] = {l4_port[1][7:0], b};
                if (pos + 1 >= UDP_HDR_LEN) begin
                    emit_header_record(is_last);
                    return;
                end
            end
            default: begin
                r              = '0;
                r.kind         = KIND_PAY;
                r.payload_byte = b;
                r.frame_end    = is_last;
                parse_results_q.push_back(r);
                byte_pos = '0;
                if (is_last)
                    restart_frame();
                return;
            end
        endcase
        // Frame ended before the headers were complete.
        if (is_last)
            raise_error(ERR_TRUNC, is_last);
    endtask

    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom) : fill[7:0];
    endfunction

    function automatic logic [3:0] pick_len_nibble();
        return ($urandom_range(9) < 6) ? 4'd5 : 4'($urandom_range(15));
    endfunction

    function automatic t_frame_spec make_spec(input logic [15:0] etype, input logic [3:0] ihl,
                                              input logic [7:0] proto, input logic [3:0] doff,
                                              input int pay_len, input int fill, input int cut);
        t_frame_spec s;
        s.etype   = etype;
        s.ihl     = ihl;
        s.proto   = proto;
        s.doff    = doff;
        s.pay_len = pay_len;
        s.fill    = fill;
        s.cut     = cut;
        return s;
    endfunction

    // Mostly well-formed frames; the rest carry a bad EtherType, a bad protocol or a cut.
    function automatic t_frame_spec random_spec();
        t_frame_spec s;
        int          sel;
        sel       = $urandom_range(99);
        s.etype   = ($urandom_range(3) == 0) ? ETYPE_VLAN : ETYPE_IPV4;
        s.proto   = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        s.ihl     = pick_len_nibble();
        s.doff    = pick_len_nibble();
        s.pay_len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        s.fill    = RANDOM_FILL;
        s.cut     = NO_CUT;
        if (sel < 10)
            s.etype = $urandom_range(1) ? 16'($urandom)
                                        : ETYPE_IPV4 ^ (16'h0001 << $urandom_range(15));
        else if (sel < 20)
            s.proto = $urandom_range(1) ? 8'($urandom)
                                        : PROTO_UDP ^ (8'h01 << $urandom_range(7));
        else if (sel < 32)
            s.cut = RANDOM_CUT;
        return s;
    endfunction

    function automatic void build_frame(input t_frame_spec s, output logic [7:0] fb[$]);
        int         ip_len;
        int         l4_len;
        int         cut_len;
        logic [7:0] fr;
        fb = {};
        repeat (12) fb.push_back(fill_byte(s.fill));
        fb.push_back(s.etype[15:8]);
        fb.push_back(s.etype[7:0]);
        if (s.etype == ETYPE_VLAN)
            repeat (4) fb.push_back(fill_byte(s.fill));
        if (s.etype == ETYPE_IPV4 || s.etype == ETYPE_VLAN) begin
            ip_len = (s.ihl < 5) ? 20 : s.ihl * 4;
            for (int i = 0; i < ip_len; i++) begin
                fr = fill_byte(s.fill);
                if (i == 0)
                    fb.push_back({fr[7:4], s.ihl});
                else if (i == 9)
                    fb.push_back(s.proto);
                else
                    fb.push_back(fr);
            end
            if (s.proto == PROTO_TCP)
                l4_len = (s.doff < 5) ? 20 : s.doff * 4;
            else if (s.proto == PROTO_UDP)
                l4_len = 8;
            else
                l4_len = 0;
            for (int i = 0; i < l4_len; i++) begin
                fr = fill_byte(s.fill);
                if (i == 12 && s.proto == PROTO_TCP)
                    fb.push_back({s.doff, fr[3:0]});
                else
                    fb.push_back(fr);
            end
        end
        repeat (s.pay_len) fb.push_back(fill_byte(s.fill));
        cut_len = (s.cut < 0) ? $urandom_range(1, fb.size()) : s.cut;
        while (cut_len > 0 && fb.size() > cut_len)
            void'(fb.pop_back());
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (src_idle_en && $urandom_range(99) < 26) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        i_s_axis_tlast  = is_last;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        parse_byte(b, is_last);
        bytes_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic send_frame(input t_frame_spec s);
        logic [7:0] fb[$];
        build_frame(s, fb);
        foreach (fb[i])
            send_byte(fb[i], i == fb.size() - 1);
    endtask

    task automatic wait_drained();
        while (parse_results_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        // All-zero and all-one content, then a VLAN-tagged UDP frame.
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 3, 8'h00, NO_CUT));
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 3, 8'hff, NO_CUT));
        send_frame(make_spec(ETYPE_VLAN, 4'd5, PROTO_UDP, 4'd5, 4, RANDOM_FILL, NO_CUT));
        // Longest IP and TCP headers, then lengths below the minimum.
        send_frame(make_spec(ETYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 2, RANDOM_FILL, NO_CUT));
        send_frame(make_spec(ETYPE_IPV4, 4'd0, PROTO_UDP, 4'd0, 2, RANDOM_FILL, NO_CUT));
        send_frame(make_spec(ETYPE_IPV4, 4'd4, PROTO_TCP, 4'd0, 1, RANDOM_FILL, NO_CUT));
        // Bad EtherType with the rest dropped, on the last byte, and one bit off.
        send_frame(make_spec(16'h86dd, 4'd5, PROTO_TCP, 4'd5, 6, RANDOM_FILL, NO_CUT));
        send_frame(make_spec(16'h0806, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, 14));
        send_frame(make_spec(16'h0801, 4'd5, PROTO_TCP, 4'd5, 2, RANDOM_FILL, NO_CUT));
        // Bad protocol with the rest dropped, and on the last byte.
        send_frame(make_spec(ETYPE_IPV4, 4'd5, 8'd1, 4'd5, 3, RANDOM_FILL, NO_CUT));
        send_frame(make_spec(ETYPE_IPV4, 4'd5, 8'hff, 4'd5, 0, RANDOM_FILL, 24));
        // Frames that stop inside the Ethernet, VLAN, IP and TCP headers.
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, 1));
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, 14));
        send_frame(make_spec(ETYPE_VLAN, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, 16));
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_UDP, 4'd5, 0, RANDOM_FILL, 30));
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, 44));
        // Headers that end exactly on the last byte.
        send_frame(make_spec(ETYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 0, RANDOM_FILL, NO_CUT));
        send_frame(make_spec(ETYPE_VLAN, 4'd5, PROTO_UDP, 4'd5, 0, RANDOM_FILL, NO_CUT));
    endtask

    task automatic test_random_frames(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_frame(random_spec());
    endtask

    task automatic test_back_to_back();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        test_random_frames(300);
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    // The sender holds off until every pending result has been taken.
    task automatic test_drain_pause();
        repeat (3) begin
            send_frame(random_spec());
            wait_drained();
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got              = '0;
        got.kind         = o_m_axis_tuser;
        got.dst_mac      = o_m_axis_tdata[47:0];
        got.src_mac      = o_m_axis_tdata[95:48];
        got.src_ip       = o_m_axis_tdata[127:96];
        got.dst_ip       = o_m_axis_tdata[159:128];
        got.is_udp       = o_m_axis_tdata[160];
        got.src_port     = o_m_axis_tdata[176:161];
        got.dst_port     = o_m_axis_tdata[192:177];
        got.tcp_flags    = o_m_axis_tdata[200:193];
        got.error_code   = o_m_axis_tdata[202:201];
        got.payload_byte = o_m_axis_tdata[210:203];
        got.frame_end    = o_m_axis_tlast;
        if (parse_results_q.size() == 0) begin
            report_mismatch($sformatf("result of kind %0d with none pending", got.kind));
            return;
        end
        want = parse_results_q.pop_front();
        compare_field("kind", 64'(got.kind), 64'(want.kind));
        compare_field("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
        compare_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
        compare_field("src_ip", 64'(got.src_ip), 64'(want.src_ip));
        compare_field("dst_ip", 64'(got.dst_ip), 64'(want.dst_ip));
        compare_field("is_udp", 64'(got.is_udp), 64'(want.is_udp));
        compare_field("src_port", 64'(got.src_port), 64'(want.src_port));
        compare_field("dst_port", 64'(got.dst_port), 64'(want.dst_port));
        compare_field("tcp_flags", 64'(got.tcp_flags), 64'(want.tcp_flags));
        compare_field("error_code", 64'(got.error_code), 64'(want.error_code));
        compare_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
        compare_field("frame_end", 64'(got.frame_end), 64'(want.frame_end));
        compare_field("zero fill", 64'(o_m_axis_tdata[215:211]), '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_result();
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= !(sink_stall_en && $urandom_range(99) < 26);
    end

    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        clear_parser_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_frames(300);
        test_drain_pause();
        test_back_to_back();
        test_random_frames(300);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/eihp_pkg.sv
hdl/eihp_core.sv
hdl/eth_ipv4_l4_header_parser_unit.sv
test/tb.sv
